// ----- hdl/efc_pkg.sv -----
package efc_pkg;

   // curve selector codes
   localparam logic [2:0] OP_LINEAR      = 3'd0;
   localparam logic [2:0] OP_OUT_CUBIC   = 3'd1;
   localparam logic [2:0] OP_INOUT_CUBIC = 3'd2;
   localparam logic [2:0] OP_OUT_QUINT   = 3'd3;
   localparam logic [2:0] OP_BOUNCE      = 3'd4;
   localparam logic [2:0] OP_ELASTIC     = 3'd5;

   localparam logic [16:0] ONE_FX = 17'd65536;

   // bounce: 7.5625 in 16.16 is 121 * 4096, so the gain step is *121 then >>4
   localparam logic [15:0] BOUNCE_GAIN = 16'd121;

   // what is left to do on an item as it moves down the pipe
   typedef enum logic [2:0] {
      MODE_DONE,
      MODE_BOUNCE,
      MODE_EL_UP,
      MODE_EL_DOWN,
      MODE_CUBE_OUT,
      MODE_CUBE_LOW,
      MODE_CUBE_HIGH,
      MODE_QUINT
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [16:0] res;
      logic [16:0] mul_a;
      logic [15:0] mul_b;
      logic [15:0] aux;
   } stage_a_type;

   typedef struct packed {
      mode_type    mode;
      logic [16:0] res;
      logic [32:0] prod;
      logic [15:0] aux;
   } stage_b_type;

   typedef struct packed {
      mode_type    mode;
      logic [16:0] res;
      logic [47:0] prod;
      logic [15:0] aux;
   } stage_c_type;

   // out-elastic knots, spaced 1/8 apart
   function automatic logic [16:0] elastic_point(input logic [3:0] idx);
      logic [16:0] v;
      case (idx)
         4'd0:    v = 17'd0;
         4'd1:    v = 17'd88836;
         4'd2:    v = 17'd49152;
         4'd3:    v = 17'd70449;
         4'd4:    v = 17'd63570;
         4'd5:    v = 17'd66322;
         4'd6:    v = 17'd65208;
         4'd7:    v = 17'd65667;
         default: v = 17'd65536;
      endcase
      return v;
   endfunction

endpackage

// ----- hdl/efc_decode.sv -----
module efc_decode import efc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_op,
   input  logic signed [31:0] req_progress,
   output logic               a_valid,
   output stage_a_type        a_data,
   input  logic               a_ready
);

   logic        a_valid_ff;
   stage_a_type a_data_ff;
   stage_a_type a_data_in;
   logic        open;

   logic [15:0] p;
   logic [15:0] q;
   logic [15:0] mag;
   logic [16:0] offset;
   logic [16:0] v0;
   logic [16:0] v1;
   logic [16:0] ediff;
   logic [3:0]  idx;
   logic        is_zero;
   logic        is_one;

   always_comb begin
      p       = req_progress[15:0];
      q       = 16'(ONE_FX - {1'b0, p});
      is_zero = (req_progress == '0) || req_progress[31];
      is_one  = req_progress[30:16] != '0;

      // bounce piece and distance from its center
      if (p < 16'd23795) begin
         mag    = p;
         offset = 17'd0;
      end else if (p < 16'd47590) begin
         mag    = (p >= 16'd35692) ? p - 16'd35692 : 16'd35692 - p;
         offset = 17'd49152;
      end else if (p < 16'd59487) begin
         mag    = (p >= 16'd53538) ? p - 16'd53538 : 16'd53538 - p;
         offset = 17'd60621;
      end else begin
         mag    = (p >= 16'd62462) ? p - 16'd62462 : 16'd62462 - p;
         offset = 17'd64512;
      end

      // elastic segment
      idx   = {1'b0, p[15:13]};
      v0    = elastic_point(idx);
      v1    = elastic_point(idx + 4'd1);
      ediff = (v1 >= v0) ? v1 - v0 : v0 - v1;

      a_data_in.mode  = MODE_DONE;
      a_data_in.res   = {1'b0, p};
      a_data_in.mul_a = {1'b0, q};
      a_data_in.mul_b = q;
      a_data_in.aux   = q;

      if (is_zero) begin
         a_data_in.res = '0;
      end else if (is_one) begin
         a_data_in.res = ONE_FX;
      end else begin
         case (req_op)
            OP_OUT_CUBIC: begin
               a_data_in.mode = MODE_CUBE_OUT;
            end
            OP_INOUT_CUBIC: begin
               if (p < 16'd32768) begin
                  a_data_in.mode  = MODE_CUBE_LOW;
                  a_data_in.mul_a = {1'b0, p};
                  a_data_in.mul_b = p;
                  a_data_in.aux   = p;
               end else begin
                  // 2*(1-p) cubed >> 33 equals (1-p) cubed >> 30
                  a_data_in.mode = MODE_CUBE_HIGH;
               end
            end
            OP_OUT_QUINT: begin
               a_data_in.mode = MODE_QUINT;
            end
            OP_BOUNCE: begin
               a_data_in.mode  = MODE_BOUNCE;
               a_data_in.res   = offset;
               a_data_in.mul_a = {1'b0, mag};
               a_data_in.mul_b = mag;
            end
            OP_ELASTIC: begin
               a_data_in.mode  = (v1 >= v0) ? MODE_EL_UP : MODE_EL_DOWN;
               a_data_in.res   = v0;
               a_data_in.mul_a = ediff;
               a_data_in.mul_b = {p[12:0], 3'b000};
            end
            default: begin
               a_data_in.mode = MODE_DONE;
            end
         endcase
      end
   end

   assign open      = !a_valid_ff || a_ready;
   assign req_stall = !open;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (open) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (open && req_valid) begin
         a_data_ff <= a_data_in;
      end
   end

   assign a_valid = a_valid_ff;
   assign a_data  = a_data_ff;

endmodule

// ----- hdl/efc_mult.sv -----
module efc_mult import efc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        a_valid,
   input  stage_a_type a_data,
   output logic        a_ready,
   output logic        c_valid,
   output stage_c_type c_data,
   input  logic        c_ready
);

   logic        b_valid_ff;
   stage_b_type b_data_ff;
   stage_b_type b_data_in;
   logic        c_valid_ff;
   stage_c_type c_data_ff;
   stage_c_type c_data_in;
   logic        b_open;
   logic        c_open;

   logic [31:0] x;
   logic [15:0] y;
   logic [15:0] q2;
   logic [33:0] rounded;

   // first multiply: square, bounce square or elastic step
   always_comb begin
      b_data_in.mode = a_data.mode;
      b_data_in.res  = a_data.res;
      b_data_in.aux  = a_data.aux;
      b_data_in.prod = 33'(a_data.mul_a) * 33'(a_data.mul_b);
   end

   // second multiply, elastic finishes here
   always_comb begin
      q2      = b_data_ff.prod[31:16];
      rounded = 34'(b_data_ff.prod) + 34'd65535;
      x       = '0;
      y       = '0;

      c_data_in.mode = b_data_ff.mode;
      c_data_in.res  = b_data_ff.res;
      c_data_in.aux  = b_data_ff.aux;

      case (b_data_ff.mode)
         MODE_CUBE_OUT, MODE_CUBE_LOW, MODE_CUBE_HIGH: begin
            x = b_data_ff.prod[31:0];
            y = b_data_ff.aux;
         end
         MODE_QUINT: begin
            x = {16'b0, q2};
            y = q2;
         end
         MODE_BOUNCE: begin
            x = {16'b0, q2};
            y = BOUNCE_GAIN;
         end
         MODE_EL_UP: begin
            c_data_in.mode = MODE_DONE;
            c_data_in.res  = b_data_ff.res + b_data_ff.prod[32:16];
         end
         MODE_EL_DOWN: begin
            // remainder rounds toward minus infinity
            c_data_in.mode = MODE_DONE;
            c_data_in.res  = b_data_ff.res - 17'(rounded >> 16);
         end
         default: begin
            x = '0;
         end
      endcase

      c_data_in.prod = 48'(x) * 48'(y);
   end

   assign c_open  = !c_valid_ff || c_ready;
   assign b_open  = !b_valid_ff || c_open;
   assign a_ready = b_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (b_open) begin
            b_valid_ff <= a_valid;
         end
         if (c_open) begin
            c_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_open && a_valid) begin
         b_data_ff <= b_data_in;
      end
      if (c_open && b_valid_ff) begin
         c_data_ff <= c_data_in;
      end
   end

   assign c_valid = c_valid_ff;
   assign c_data  = c_data_ff;

endmodule

// ----- hdl/efc_finish.sv -----
module efc_finish import efc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        c_valid,
   input  stage_c_type c_data,
   output logic        c_ready,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [16:0] rsp_eased_value
);

   logic        rsp_valid_ff;
   logic [16:0] rsp_eased_value_ff;
   logic [16:0] rsp_eased_value_in;
   logic        open;
   logic [31:0] prod3;

   always_comb begin
      // third quint multiply: q^4 * q
      prod3 = 32'(c_data.prod[31:16]) * 32'(c_data.aux);

      case (c_data.mode)
         MODE_BOUNCE:    rsp_eased_value_in = c_data.res + c_data.prod[20:4];
         MODE_CUBE_OUT:  rsp_eased_value_in = ONE_FX - {1'b0, c_data.prod[47:32]};
         MODE_CUBE_LOW:  rsp_eased_value_in = c_data.prod[46:30];
         MODE_CUBE_HIGH: rsp_eased_value_in = ONE_FX - c_data.prod[46:30];
         MODE_QUINT:     rsp_eased_value_in = ONE_FX - {1'b0, prod3[31:16]};
         default:        rsp_eased_value_in = c_data.res;
      endcase
   end

   assign open    = !rsp_valid_ff || !rsp_stall;
   assign c_ready = open;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (open) begin
         rsp_valid_ff <= c_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (open && c_valid) begin
         rsp_eased_value_ff <= rsp_eased_value_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_eased_value = rsp_eased_value_ff;

endmodule

// ----- hdl/fixed_point_easing_curve.sv -----
// Fixed-point easing curve unit, 16.16 in and out.
// Request channel: req_valid / req_stall with req_op (curve) and req_progress
// (signed 16.16). A request is taken on a rising edge with req_valid high and
// req_stall low. Result channel: rsp_valid / rsp_stall with rsp_eased_value
// (unsigned 16.16, up to 88836 for elastic overshoot).
// Progress at or below zero gives 0, at or above one gives 65536.
// Pipeline: decode register, two multiply stages, output register. With no
// stall a request passes from the decode register through both multiply
// stages to the output register (four registers deep). One request per cycle
// is sustained while rsp_stall is low; each stage takes one when the next moves.
// Each stage carries its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up under back-pressure. When the
// receiver holds rsp_stall, the output register keeps its value and the stages
// behind it fill; req_stall rises only once all four hold requests.
// Reset (synchronous, active high) clears every valid bit; data registers are
// not reset. Results come out in request order, one per request.
module fixed_point_easing_curve import efc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_op,
   input  logic signed [31:0] req_progress,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [16:0]        rsp_eased_value
);

   // clamp, curve decode, operand select, elastic table lookup
   logic        a_valid;
   stage_a_type a_data;
   logic        a_ready;
   // squares, then cubes / fourth power / bounce gain
   logic        c_valid;
   stage_c_type c_data;
   logic        c_ready;

   efc_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_progress (req_progress),
      .a_valid      (a_valid),
      .a_data       (a_data),
      .a_ready      (a_ready)
   );

   efc_mult u_mult (
      .clock   (clock),
      .reset   (reset),
      .a_valid (a_valid),
      .a_data  (a_data),
      .a_ready (a_ready),
      .c_valid (c_valid),
      .c_data  (c_data),
      .c_ready (c_ready)
   );

   // quint's last multiply and the final subtract, into the output register
   efc_finish u_finish (
      .clock           (clock),
      .reset           (reset),
      .c_valid         (c_valid),
      .c_data          (c_data),
      .c_ready         (c_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_eased_value (rsp_eased_value)
   );

endmodule

// ----- hdl/efc_checker.sv -----
module efc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic signed [31:0] req_progress,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [16:0]        rsp_eased_value
);

   localparam logic [16:0] PEAK = 17'd88836;

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_eased_value))
      else $error("result changed while stalled");

   // nothing is presented right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_eased_value <= PEAK)
      else $error("eased value out of range");

   // negative progress, rsp_stall low on the way: zero comes out of the pipe
   a_neg_zero: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_progress[31]) ##1 !rsp_stall ##1 !rsp_stall
         ##1 !rsp_stall |=> rsp_valid && rsp_eased_value == '0)
      else $error("negative progress did not give zero on time");

endmodule

bind fixed_point_easing_curve efc_checker u_efc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_progress    (req_progress),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_eased_value (rsp_eased_value)
);

// ----- tb/sv/tb_fixed_point_easing_curve.sv -----
module tb_fixed_point_easing_curve;
   import efc_pkg::*;

   // selector codes with no curve of their own; the block treats them as linear
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   // bounce piece breakpoints, arc centers and arc bases (16.16)
   localparam logic [63:0] BOUNCE_EDGE_1 = 64'd23795;
   localparam logic [63:0] BOUNCE_EDGE_2 = 64'd47590;
   localparam logic [63:0] BOUNCE_EDGE_3 = 64'd59487;
   localparam logic [63:0] BOUNCE_MID_2  = 64'd35692;
   localparam logic [63:0] BOUNCE_MID_3  = 64'd53538;
   localparam logic [63:0] BOUNCE_MID_4  = 64'd62462;
   localparam logic [63:0] BOUNCE_BASE_2 = 64'd49152;
   localparam logic [63:0] BOUNCE_BASE_3 = 64'd60621;
   localparam logic [63:0] BOUNCE_BASE_4 = 64'd64512;
   localparam logic [63:0] BOUNCE_SCALE  = 64'd495616;   // 7.5625 in 16.16

   // elastic knots at steps of 1/8; entry 0 is the rightmost in the concatenation
   localparam logic [8:0][16:0] ELASTIC_KNOTS = {
      17'd65536, 17'd65667, 17'd65208, 17'd66322, 17'd63570,
      17'd70449, 17'd49152, 17'd88836, 17'd0
   };

   localparam int RESET_CYCLES  = 8;
   localparam int DRAIN_CYCLES  = 8;      // pipe is four registers deep
   localparam int RANDOM_COUNT  = 900;
   localparam int HOLD_CYCLES   = 48;     // long receiver hold-off
   localparam int CYCLE_LIMIT   = 200000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_op = OP_LINEAR;
   logic signed [31:0] req_progress = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [16:0]        rsp_eased_value;

   logic [16:0] pending_eased [$];   // eased values still owed, oldest first
   int          mismatch_count = 0;
   int          cycle_count = 0;
   bit          calm = 1'b0;         // no sender idling and no random receiver stalls while set
   bit          squeeze = 1'b0;      // asks the receiver for one long hold-off

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] progress;
      logic        known;     // eased value typed in below
      logic [16:0] eased;
   } ease_row_type;

   // directed requests: clamps, selector extremes, piece boundaries.
   // Rows with known = 0 are checked against the predictor.
   ease_row_type directed_rows [25] = '{
      '{OP_LINEAR,      32'h0000_0000, 1'b1, 17'd0},      // zero progress
      '{OP_OUT_QUINT,   32'h8000_0000, 1'b1, 17'd0},      // most negative
      '{OP_BOUNCE,      32'hFFFF_FFFF, 1'b1, 17'd0},      // minus one lsb
      '{OP_ELASTIC,     32'h0001_0000, 1'b1, 17'd65536},  // exactly one
      '{OP_OUT_CUBIC,   32'h7FFF_FFFF, 1'b1, 17'd65536},  // most positive
      '{OP_INOUT_CUBIC, 32'h0001_0001, 1'b1, 17'd65536},  // just past one
      '{OP_LINEAR,      32'd1,         1'b1, 17'd1},
      '{OP_LINEAR,      32'd65535,     1'b1, 17'd65535},
      '{OP_SPARE_A,     32'd12345,     1'b1, 17'd12345},  // unused selector
      '{OP_SPARE_B,     32'd40000,     1'b1, 17'd40000},  // unused selector
      '{OP_ELASTIC,     32'd8192,      1'b1, 17'd88836},  // on the overshoot knot
      '{OP_ELASTIC,     32'd16384,     1'b1, 17'd49152},  // on a knot
      '{OP_ELASTIC,     32'd65535,     1'b0, 17'd0},      // last segment
      '{OP_ELASTIC,     32'd12000,     1'b0, 17'd0},      // falling segment
      '{OP_OUT_CUBIC,   32'd1,         1'b0, 17'd0},
      '{OP_OUT_CUBIC,   32'd65535,     1'b0, 17'd0},
      '{OP_INOUT_CUBIC, 32'd32767,     1'b0, 17'd0},      // last of lower half
      '{OP_INOUT_CUBIC, 32'd32768,     1'b0, 17'd0},      // first of upper half
      '{OP_OUT_QUINT,   32'd1,         1'b0, 17'd0},
      '{OP_OUT_QUINT,   32'd30000,     1'b0, 17'd0},
      '{OP_BOUNCE,      32'd23794,     1'b0, 17'd0},      // bounce piece edges
      '{OP_BOUNCE,      32'd23795,     1'b0, 17'd0},
      '{OP_BOUNCE,      32'd47590,     1'b0, 17'd0},
      '{OP_BOUNCE,      32'd59487,     1'b0, 17'd0},
      '{OP_BOUNCE,      32'd65535,     1'b0, 17'd0}
   };

   fixed_point_easing_curve i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_progress    (req_progress),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_eased_value (rsp_eased_value)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // one bounce arc: 7.5625 * d^2, d given as a magnitude
   function automatic logic [63:0] bounce_arc(input logic [63:0] mag);
      logic [63:0] sq;
      sq = (mag * mag) >> 16;
      return (BOUNCE_SCALE * sq) >> 16;
   endfunction

   // eased value in 16.16 for one request
   function automatic logic [16:0] ease_curve(input logic [2:0] op,
                                              input logic signed [31:0] progress);
      logic [63:0] p, q, q2, q4, q5, prod, r;
      logic [31:0] scaled;
      logic [3:0]  idx;
      logic [15:0] frac;
      logic [16:0] v0, v1;
      if (progress <= 0)
         return 17'd0;
      if (progress >= 32'sd65536)
         return ONE_FX;
      p = {32'd0, progress};
      case (op)
         OP_OUT_CUBIC: begin
            q = 64'd65536 - p;
            r = 64'd65536 - ((q * q * q) >> 32);
         end
         OP_INOUT_CUBIC: begin
            if (p < 64'd32768) begin
               r = (64'd4 * p * p * p) >> 32;
            end else begin
               q = 64'd131072 - 64'd2 * p;
               r = 64'd65536 - (((q * q * q) >> 32) >> 1);
            end
         end
         OP_OUT_QUINT: begin
            // truncated back to 16.16 after every multiply
            q  = 64'd65536 - p;
            q2 = (q * q) >> 16;
            q4 = (q2 * q2) >> 16;
            q5 = (q4 * q) >> 16;
            r  = 64'd65536 - q5;
         end
         OP_BOUNCE: begin
            if (p < BOUNCE_EDGE_1)
               r = bounce_arc(p);
            else if (p < BOUNCE_EDGE_2)
               r = bounce_arc(p >= BOUNCE_MID_2 ? p - BOUNCE_MID_2 : BOUNCE_MID_2 - p)
                   + BOUNCE_BASE_2;
            else if (p < BOUNCE_EDGE_3)
               r = bounce_arc(p >= BOUNCE_MID_3 ? p - BOUNCE_MID_3 : BOUNCE_MID_3 - p)
                   + BOUNCE_BASE_3;
            else
               r = bounce_arc(p >= BOUNCE_MID_4 ? p - BOUNCE_MID_4 : BOUNCE_MID_4 - p)
                   + BOUNCE_BASE_4;
         end
         OP_ELASTIC: begin
            // segment from the top three bits of progress, slope at full width;
            // falling segments round the drop up, i.e. the value toward minus infinity
            scaled = p[31:0] * 32'd8;
            idx    = {1'b0, scaled[18:16]};
            frac   = scaled[15:0];
            v0     = ELASTIC_KNOTS[idx];
            v1     = ELASTIC_KNOTS[idx + 4'd1];
            if (v1 >= v0) begin
               prod = {47'd0, v1 - v0} * {48'd0, frac};
               r    = {47'd0, v0} + (prod >> 16);
            end else begin
               prod = {47'd0, v0 - v1} * {48'd0, frac};
               r    = {47'd0, v0} - ((prod + 64'd65535) >> 16);
            end
         end
         default: r = p;   // linear, spare codes included
      endcase
      return r[16:0];
   endfunction

   // sender idle length: mostly none, often short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // random progress: mostly inside the curve range, some clamps, some raw words
   function automatic logic [31:0] pick_progress();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 5))
               0: return 32'd0;
               1: return 32'h8000_0000;
               2: return 32'h7FFF_FFFF;
               3: return 32'd65536;
               4: return 32'hFFFF_FFFF - $urandom_range(0, 65535);
               default: return 32'd65536 + $urandom_range(0, 65535);
            endcase
         end
         default: return $urandom_range(1, 65535);
      endcase
   endfunction

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // offer one request and hold it until taken; record what it must produce
   task automatic send_request(input logic [2:0] op, input logic [31:0] progress,
                               input logic known, input logic [16:0] eased);
      req_valid    <= 1'b1;
      req_op       <= op;
      req_progress <= progress;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_eased.push_back(known ? eased : ease_curve(op, progress));
   endtask

   // stimulus
   initial begin
      int k;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < $size(directed_rows); k++) begin
         idle_for(pick_gap());
         send_request(directed_rows[k].op, directed_rows[k].progress,
                      directed_rows[k].known, directed_rows[k].eased);
      end

      for (k = 0; k < RANDOM_COUNT; k++) begin
         // back-to-back stretch with a ready receiver
         if (k == 100) calm = 1'b1;
         if (k == 180) calm = 1'b0;
         // long receiver hold-off while requests keep coming: pipe fills,
         // req_stall has to rise and the held requests must come out intact
         if (k == 400) begin
            calm    = 1'b1;
            squeeze = 1'b1;
         end
         if (k == 470) calm = 1'b0;
         idle_for(pick_gap());
         send_request(3'($urandom_range(0, 7)), pick_progress(), 1'b0, 17'd0);
      end
      req_valid <= 1'b0;

      while (pending_eased.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // receiver: random stall runs, none while calm, one long hold-off on request
   initial begin
      int run;
      forever begin
         @(posedge clock);
         if (squeeze) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            squeeze = 1'b0;
            rsp_stall <= 1'b0;
         end else if (calm || $urandom_range(0, 99) < 60) begin
            rsp_stall <= 1'b0;
         end else begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (run) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // result check: each taken result against the oldest owed value
   always @(posedge clock) begin
      logic [16:0] want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_eased.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, actual %0d",
                     $time, rsp_eased_value);
         end else begin
            want = pending_eased.pop_front();
            if (rsp_eased_value !== want) begin
               mismatch_count++;
               $display("%0t: eased_value mismatch, expected %0d, actual %0d",
                        $time, want, rsp_eased_value);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

endmodule
